FILE: sv/bta_pkg.sv
package bta_pkg;

    localparam int ADDR_W  = 47;
    localparam int ALIGN_W = 23;
    localparam int ENTRY_W = ADDR_W + 1;
    localparam int STAT_W  = 3;
    localparam int CIDX_W  = 8;

    localparam logic [ALIGN_W-1:0] MIN_ALIGN = 23'h10;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [CIDX_W-1:0] REG_HEAP_LOW  = 8'd0;
    localparam logic [CIDX_W-1:0] REG_HEAP_HIGH = 8'd1;

    localparam logic [0:0] CMD_ALLOC = 1'b0;

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE,
        S_A_TOP, S_A_TOPW, S_A_RD, S_A_CALC, S_A_CHECK,
        S_SH_RD, S_SH_WR, S_PLACE,
        S_F_RD, S_F_CHK,
        S_M_RD0, S_M_W0, S_M_RD, S_M_CHK, S_D_RD, S_D_WR,
        S_DONE
    } t_state;

endpackage

FILE: sv/bta_ram.sv
module bta_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/boundary_table_aligned_allocator.sv
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    cmd, alignment, request_size, block_address
// out      output     o_out_valid / i_out_ready  granted_address, status
// cfg      input      i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// one item at a time; the boundary table sits in a single ram with a registered read.
// an allocate scans the regions from the top of the table down, a free scans the
// entries for the block and then checks neighbours for a merge, and an insert or
// merge shift moves the entries one place at a time.
// reset or a heap_low/heap_high write rebuilds the two heap entries in S_INIT0 and S_INIT1.
// a finished result waits in the output register while the next item is accepted.
module boundary_table_aligned_allocator #(
    parameter int TABLE_DEPTH   = 64,
    parameter int MAX_ALIGNMENT = 4194304
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [bta_pkg::ALIGN_W-1:0] i_alignment,
    input  logic [bta_pkg::ADDR_W-1:0]  i_request_size,
    input  logic [bta_pkg::ADDR_W-1:0]  i_block_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bta_pkg::ADDR_W-1:0]  o_granted_address,
    output logic [bta_pkg::STAT_W-1:0]  o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bta_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [bta_pkg::ADDR_W-1:0]  i_cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = bta_pkg::ADDR_W;
    localparam int EW = bta_pkg::ENTRY_W;
    localparam int GW = bta_pkg::ALIGN_W;
    localparam int SW = bta_pkg::STAT_W;

    bta_pkg::t_state r_state, n_state;
    logic [IW-1:0] r_i, n_i, r_j, n_j;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_size, n_size, r_addr, n_addr, r_e, n_e, r_b, n_b;
    logic [AW-1:0] r_place, n_place, r_grant, n_grant;
    logic [GW-1:0] r_mask, n_mask;
    logic [AW:0]   r_diff, n_diff, r_tail, n_tail;
    logic          r_bused, n_bused, r_bge, n_bge, r_pused, n_pused, r_ins, n_ins;
    logic [SW-1:0] r_st, n_st;
    logic          r_ovalid, n_ovalid;
    logic [AW-1:0] r_ogrant, n_ogrant;
    logic [SW-1:0] r_ost, n_ost;
    logic [AW-1:0] r_heap_low, n_heap_low, r_heap_high, n_heap_high;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic          in_acc, cfg_acc, bad;
    logic [GW-1:0] align_m;
    logic [AW:0]   rem, need, cand;
    logic [CW-1:0] i_p1, j_p1;

    bta_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_cfg_ready = (r_state == bta_pkg::S_IDLE);
    assign o_in_ready  = (r_state == bta_pkg::S_IDLE) && !i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && o_in_ready;

    assign o_out_valid       = r_ovalid;
    assign o_granted_address = r_ogrant;
    assign o_status          = r_ost;

    assign bad = (i_alignment == '0) || ({9'd0, i_alignment} > 32'(MAX_ALIGNMENT))
              || ((i_alignment & (i_alignment - GW'(1))) != '0) || (i_request_size == '0);
    assign align_m = ((i_alignment < bta_pkg::MIN_ALIGN) ? bta_pkg::MIN_ALIGN : i_alignment)
                   - GW'(1);

    assign rem  = (AW+1)'(r_tail[GW-1:0] & r_mask);
    assign need = {1'b0, r_size} + rem;
    assign cand = r_tail - rem;
    assign i_p1 = CW'(r_i) + CW'(1);
    assign j_p1 = CW'(r_j) + CW'(1);

    // next state and datapath registers
    always_comb begin
        n_state = r_state;
        n_i = r_i;   n_j = r_j;   n_cnt = r_cnt;
        n_size = r_size; n_addr = r_addr; n_e = r_e; n_b = r_b;
        n_place = r_place; n_grant = r_grant; n_mask = r_mask;
        n_diff = r_diff; n_tail = r_tail; n_bused = r_bused; n_bge = r_bge;
        n_pused = r_pused; n_ins = r_ins; n_st = r_st;
        n_ovalid = r_ovalid && !i_out_ready;
        n_ogrant = r_ogrant; n_ost = r_ost;
        n_heap_low = r_heap_low; n_heap_high = r_heap_high;
        unique case (r_state)
            bta_pkg::S_INIT0: n_state = bta_pkg::S_INIT1;
            bta_pkg::S_INIT1: begin
                n_cnt   = CW'(2);
                n_state = bta_pkg::S_IDLE;
            end
            bta_pkg::S_IDLE: begin
                if (cfg_acc) begin
                    if (i_cfg_index == bta_pkg::REG_HEAP_LOW) begin
                        n_heap_low = i_cfg_data;
                        n_state    = bta_pkg::S_INIT0;
                    end else if (i_cfg_index == bta_pkg::REG_HEAP_HIGH) begin
                        n_heap_high = i_cfg_data;
                        n_state     = bta_pkg::S_INIT0;
                    end
                end else if (in_acc) begin
                    n_size  = i_request_size;
                    n_addr  = i_block_address;
                    n_mask  = align_m;
                    n_grant = '0;
                    n_i     = '0;
                    if (i_cmd != bta_pkg::CMD_ALLOC) begin
                        n_state = bta_pkg::S_F_RD;
                    end else if (bad) begin
                        n_st    = bta_pkg::ST_BAD;
                        n_state = bta_pkg::S_DONE;
                    end else begin
                        n_state = bta_pkg::S_A_TOP;
                    end
                end
            end
            bta_pkg::S_A_TOP: n_state = bta_pkg::S_A_TOPW;
            bta_pkg::S_A_TOPW: begin
                n_e     = ram_rdata[AW-1:0];
                n_i     = IW'(r_cnt - CW'(1));
                n_state = bta_pkg::S_A_RD;
            end
            bta_pkg::S_A_RD: begin
                if (r_i == '0) begin
                    n_st    = bta_pkg::ST_NOSPACE;
                    n_state = bta_pkg::S_DONE;
                end else begin
                    n_state = bta_pkg::S_A_CALC;
                end
            end
            bta_pkg::S_A_CALC: begin
                n_b     = ram_rdata[AW-1:0];
                n_bused = ram_rdata[EW-1];
                n_bge   = ram_rdata[AW-1:0] >= r_e;
                n_diff  = {1'b0, r_e} - {1'b0, ram_rdata[AW-1:0]};
                n_tail  = {1'b0, r_e} - {1'b0, r_size};
                n_state = bta_pkg::S_A_CHECK;
            end
            bta_pkg::S_A_CHECK: begin
                if (!r_bused && r_bge) begin
                    n_st    = bta_pkg::ST_NOSPACE;
                    n_state = bta_pkg::S_DONE;
                end else if (!r_bused && ({1'b0, r_size} <= r_diff) && (need <= r_diff)) begin
                    n_place = cand[AW-1:0];
                    n_ins   = cand[AW-1:0] != r_b;
                    if (cand[AW-1:0] == '0) begin
                        n_st    = bta_pkg::ST_NOSPACE;
                        n_state = bta_pkg::S_DONE;
                    end else if (cand[AW-1:0] != r_b) begin
                        if (r_cnt >= CW'(TABLE_DEPTH)) begin
                            n_st    = bta_pkg::ST_FULL;
                            n_state = bta_pkg::S_DONE;
                        end else begin
                            n_j     = IW'(r_cnt - CW'(1));
                            n_state = bta_pkg::S_SH_RD;
                        end
                    end else begin
                        n_i     = r_i - IW'(1);
                        n_state = bta_pkg::S_PLACE;
                    end
                end else begin
                    n_e     = r_b;
                    n_i     = r_i - IW'(1);
                    n_state = bta_pkg::S_A_RD;
                end
            end
            bta_pkg::S_SH_RD: n_state = bta_pkg::S_SH_WR;
            bta_pkg::S_SH_WR: begin
                if (r_j == r_i) begin
                    n_state = bta_pkg::S_PLACE;
                end else begin
                    n_j     = r_j - IW'(1);
                    n_state = bta_pkg::S_SH_RD;
                end
            end
            bta_pkg::S_PLACE: begin
                if (r_ins) begin
                    n_cnt = r_cnt + CW'(1);
                end
                n_grant = r_place;
                n_st    = bta_pkg::ST_OK;
                n_state = bta_pkg::S_DONE;
            end
            bta_pkg::S_F_RD: begin
                if (i_p1 >= r_cnt) begin
                    n_st    = bta_pkg::ST_NOTFOUND;
                    n_state = bta_pkg::S_M_RD0;
                end else begin
                    n_state = bta_pkg::S_F_CHK;
                end
            end
            bta_pkg::S_F_CHK: begin
                if (ram_rdata[EW-1] && (ram_rdata[AW-1:0] == r_addr)) begin
                    n_st    = bta_pkg::ST_OK;
                    n_state = bta_pkg::S_M_RD0;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = bta_pkg::S_F_RD;
                end
            end
            bta_pkg::S_M_RD0: n_state = bta_pkg::S_M_W0;
            bta_pkg::S_M_W0: begin
                n_pused = ram_rdata[EW-1];
                n_i     = IW'(1);
                n_state = bta_pkg::S_M_RD;
            end
            bta_pkg::S_M_RD: begin
                n_state = (i_p1 >= r_cnt) ? bta_pkg::S_DONE : bta_pkg::S_M_CHK;
            end
            bta_pkg::S_M_CHK: begin
                if (r_pused || ram_rdata[EW-1]) begin
                    n_pused = ram_rdata[EW-1];
                    n_i     = r_i + IW'(1);
                end else begin
                    n_j = r_i;
                end
                n_state = (r_pused || ram_rdata[EW-1]) ? bta_pkg::S_M_RD : bta_pkg::S_D_RD;
            end
            bta_pkg::S_D_RD: begin
                // entries above the dropped boundary slide down one place
                if (j_p1 >= r_cnt) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = bta_pkg::S_M_RD;
                end else begin
                    n_state = bta_pkg::S_D_WR;
                end
            end
            bta_pkg::S_D_WR: begin
                n_j     = r_j + IW'(1);
                n_state = bta_pkg::S_D_RD;
            end
            bta_pkg::S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_ogrant = r_grant;
                    n_ost    = r_st;
                    n_state  = bta_pkg::S_IDLE;
                end
            end
            default: n_state = bta_pkg::S_IDLE;
        endcase
    end

    // table ram control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        unique case (r_state)
            bta_pkg::S_INIT0: begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, r_heap_low};
            end
            bta_pkg::S_INIT1: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(1);
                ram_wdata = {1'b0, r_heap_high};
            end
            bta_pkg::S_A_TOP: ram_raddr = IW'(r_cnt - CW'(1));
            bta_pkg::S_A_RD:  ram_raddr = r_i - IW'(1);
            bta_pkg::S_SH_RD: ram_raddr = r_j;
            bta_pkg::S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j + IW'(1);
                ram_wdata = ram_rdata;
            end
            bta_pkg::S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = {1'b1, r_place};
            end
            bta_pkg::S_F_RD: ram_raddr = r_i;
            bta_pkg::S_F_CHK: begin
                ram_we    = ram_rdata[EW-1] && (ram_rdata[AW-1:0] == r_addr);
                ram_waddr = r_i;
                ram_wdata = {1'b0, ram_rdata[AW-1:0]};
            end
            bta_pkg::S_M_RD0: ram_raddr = '0;
            bta_pkg::S_M_RD:  ram_raddr = r_i;
            bta_pkg::S_D_RD:  ram_raddr = r_j + IW'(1);
            bta_pkg::S_D_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = ram_rdata;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bta_pkg::S_INIT0;
            r_cnt       <= CW'(2);
            r_ovalid    <= 1'b0;
            r_heap_low  <= 47'h0000_8000_2000;
            r_heap_high <= 47'h7FFF_FFFF_F000;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovalid    <= n_ovalid;
            r_heap_low  <= n_heap_low;
            r_heap_high <= n_heap_high;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;     r_j <= n_j;
        r_size <= n_size; r_addr <= n_addr; r_e <= n_e; r_b <= n_b;
        r_place <= n_place; r_grant <= n_grant; r_mask <= n_mask;
        r_diff <= n_diff; r_tail <= n_tail; r_bused <= n_bused; r_bge <= n_bge;
        r_pused <= n_pused; r_ins <= n_ins; r_st <= n_st;
        r_ogrant <= n_ogrant; r_ost <= n_ost;
    end

endmodule
